/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SDE_ASSERT(label, clk_s, rstn_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");
`define SDE_NEVER(label, clk_s, rstn_s, expr) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
    else $error("forbidden condition seen");
`else
`define SDE_ASSERT(label, clk_s, rstn_s, prop)
`define SDE_NEVER(label, clk_s, rstn_s, expr)
`endif

`endif

/* rtl/sde_pkg.sv */
`default_nettype none

package sde_pkg;

  // Datapath widths of the shared arithmetic unit.
  localparam int MUL_W    = 34;
  localparam int PROD_W   = 68;
  localparam int DEN_W    = 34;
  localparam int RAD_W    = 68;
  localparam int REM_W    = 38;
  localparam int SQ_STEPS = 34;
  localparam int SUM_W    = 66;
  localparam int SATW     = 72;

  // Request opcodes for the shared unit.
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } sde_op_e;

  typedef struct packed {
    logic    start;
    sde_op_e op;
  } sde_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sde_stat_t;

  // Item and register codes.
  localparam logic       CMD_STEP  = 1'b0;
  localparam logic       CMD_LOAD  = 1'b1;
  localparam logic       QTY_POS   = 1'b0;
  localparam logic       QTY_VEL   = 1'b1;
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [2:0] REG_STIFF = 3'd0;
  localparam logic [2:0] REG_REST  = 3'd1;
  localparam logic [2:0] REG_DAMP  = 3'd2;
  localparam logic [2:0] REG_MASS1 = 3'd3;
  localparam logic [2:0] REG_MASS2 = 3'd4;

  // Clamp a wide signed value into the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] x);
    logic signed [31:0] res;
    if (x[SATW-1:31] == '0 || x[SATW-1:31] == '1) begin
      res = $signed(x[31:0]);
    end else if (x[SATW-1]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/sde_unit.sv */
`default_nettype none
`include "assert_macros.svh"

// Shared arithmetic unit: a registered signed multiplier and a bit-serial
// restoring divider that also runs the digit-by-digit square root, since
// both reduce to one shift, compare and subtract per step.
module sde_unit import sde_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sde_cmd_t                 cmd,
  input  logic signed [MUL_W-1:0]  mul_a,
  input  logic signed [MUL_W-1:0]  mul_b,
  input  logic [32+FRAC_BITS:0]    div_num,
  input  logic [DEN_W-1:0]         div_den,
  input  logic [RAD_W-1:0]         rad,
  output logic signed [PROD_W-1:0] prod,
  output logic [32+FRAC_BITS:0]    quo,
  output sde_stat_t                stat
);

  localparam int DW = 33 + FRAC_BITS;
  localparam int CW = $clog2(DW);

  logic signed [PROD_W-1:0] prod_r;
  logic [RAD_W-1:0]         src_r;
  logic [REM_W-1:0]         rem_r;
  logic [DW-1:0]            quo_r;
  logic [DEN_W-1:0]         den_r;
  logic [CW-1:0]            cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic                     sqrt_mode_r;

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] rem_nxt;
  logic [REM_W:0]   diff;
  logic             ge;

  always_comb begin
    if (sqrt_mode_r) begin
      shifted = {rem_r[REM_W-3:0], src_r[RAD_W-1 -: 2]};
      trial   = {quo_r[REM_W-3:0], 2'b01};
    end else begin
      shifted = {rem_r[REM_W-2:0], src_r[RAD_W-1]};
      trial   = REM_W'(den_r);
    end
    diff    = {1'b0, shifted} - {1'b0, trial};
    ge      = ~diff[REM_W];
    rem_nxt = ge ? diff[REM_W-1:0] : shifted;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      unique case (cmd.op)
        OP_MUL: prod_r <= mul_a * mul_b;
        OP_DIV: begin
          src_r <= {div_num, {(RAD_W-DW){1'b0}}};
          rem_r <= '0;
          quo_r <= '0;
          den_r <= div_den;
        end
        OP_SQRT: begin
          src_r <= rad;
          rem_r <= '0;
          quo_r <= '0;
        end
        default: ;
      endcase
    end else if (busy_r) begin
      src_r <= sqrt_mode_r ? (src_r << 2) : (src_r << 1);
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      sqrt_mode_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start && cmd.op != OP_MUL) begin
        busy_r      <= 1'b1;
        sqrt_mode_r <= (cmd.op == OP_SQRT);
        cnt_r       <= (cmd.op == OP_SQRT) ? CW'(SQ_STEPS - 1) : CW'(DW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign prod      = prod_r;
  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `SDE_NEVER(a_start_while_busy, clk, rst_n, cmd.start && busy_r)
  `SDE_ASSERT(a_done_after_busy, clk, rst_n, done_r |-> $past(busy_r))
  `SDE_ASSERT(a_div_rem_below_den, clk, rst_n, (busy_r && !sqrt_mode_r) |-> rem_r < REM_W'(den_r))
  `SDE_ASSERT(a_root_width, clk, rst_n, (done_r && sqrt_mode_r) |-> quo_r[DW-1:SQ_STEPS] == '0)

endmodule

`default_nettype wire

/* rtl/spring_damper_euler_step.sv */
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Handshake             Contents
// in_       input      in_valid / in_stall   step or load request
// out_      output     out_valid / out_stall body positions and separation
// cfg_      input      cfg_valid / cfg_ready register index and write data
//
// A load request goes from idle straight to the hand-off state. A step request runs,
// when the bodies are apart and both masses are nonzero, nine divisions and
// one square root, each one bit per cycle through the single shared
// divide/root unit. in_stall is high for the whole of a request.
// A finished result sits in the output register, so the next request is taken
// while it waits; only the hand-off of that next result waits on out_stall.
// Reset clears both bodies to rest at the origin and the registers to defaults.
module spring_damper_euler_step import sde_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [15:0]        in_time_step,
  input  logic               in_mass_index,
  input  logic               in_quantity,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_load_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_first_x,
  output logic signed [31:0] out_first_y,
  output logic signed [31:0] out_first_z,
  output logic signed [31:0] out_second_x,
  output logic signed [31:0] out_second_y,
  output logic signed [31:0] out_second_z,
  output logic [30:0]        out_separation,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int DW = 33 + FRAC_BITS;
  localparam longint GRAV_L = ((longint'(982) << FRAC_BITS) + 50) / 100;
  localparam logic signed [SATW-1:0] GRAV = SATW'(GRAV_L);
  localparam logic [30:0] CFG_ONE = 31'(longint'(1) << FRAC_BITS);

  typedef enum logic [18:0] {
    S_IDLE    = 19'b000_0000_0000_0000_0001,
    S_SQ_MUL  = 19'b000_0000_0000_0000_0010,
    S_SQ_ACC  = 19'b000_0000_0000_0000_0100,
    S_SQRT_ST = 19'b000_0000_0000_0000_1000,
    S_SQRT_W  = 19'b000_0000_0000_0001_0000,
    S_MAG_MUL = 19'b000_0000_0000_0010_0000,
    S_MAG_SAT = 19'b000_0000_0000_0100_0000,
    S_UNIT_ST = 19'b000_0000_0000_1000_0000,
    S_UNIT_W  = 19'b000_0000_0001_0000_0000,
    S_SPRING  = 19'b000_0000_0010_0000_0000,
    S_DAMP_MUL= 19'b000_0000_0100_0000_0000,
    S_FORCE   = 19'b000_0000_1000_0000_0000,
    S_ACC_ST  = 19'b000_0001_0000_0000_0000,
    S_ACC_W   = 19'b000_0010_0000_0000_0000,
    S_VEL_MUL = 19'b000_0100_0000_0000_0000,
    S_VEL_UPD = 19'b000_1000_0000_0000_0000,
    S_POS_MUL = 19'b001_0000_0000_0000_0000,
    S_POS_UPD = 19'b010_0000_0000_0000_0000,
    S_FINISH  = 19'b100_0000_0000_0000_0000
  } state_t;

  state_t state_r;
  logic [1:0] axis_r;
  logic       body_r;
  logic       out_valid_r;

  logic [30:0] stiff_r, rest_r, damp_c_r, mass1_r, mass2_r;

  logic signed [31:0] p1_r [3];
  logic signed [31:0] p2_r [3];
  logic signed [31:0] v1_r [3];
  logic signed [31:0] v2_r [3];
  logic [30:0]        last_sep_r;

  logic [15:0]        dt_r;
  logic signed [32:0] d_r [3];
  logic [SUM_W-1:0]   sum_r;
  logic [DEN_W-1:0]   dist_r;
  logic signed [31:0] mag_r;
  logic signed [32:0] spring_r;
  logic signed [31:0] force_r [3];
  logic signed [31:0] acc_r;
  logic signed [31:0] out_pos_r [6];
  logic [30:0]        out_sep_r;

  sde_cmd_t                 ucmd;
  sde_stat_t                stat;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [DW-1:0]            div_num;
  logic [DEN_W-1:0]         div_den;
  logic signed [PROD_W-1:0] prod;
  logic [DW-1:0]            quo;

  logic                      in_acc, out_free;
  logic signed [31:0]        p1c, p2c, v1c, v2c, vcur, pcur, fcur, dv, damp;
  logic signed [31:0]        stretch, force_nxt, acc_div, acc_eff, vel_nxt, pos_nxt;
  logic signed [32:0]        dcur, dv_full, fext, fsig;
  logic signed [34:0]        stretch_full;
  logic [32:0]               dmag, fmag;
  logic                      dneg;
  logic signed [FRAC_BITS+1:0] unit_q, unit_s;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [SATW-1:0]    qs;
  logic [30:0]               mass;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    p1c  = p1_r[axis_r];
    p2c  = p2_r[axis_r];
    v1c  = v1_r[axis_r];
    v2c  = v2_r[axis_r];
    vcur = body_r ? v2c : v1c;
    pcur = body_r ? p2c : p1c;
    mass = body_r ? mass2_r : mass1_r;

    dcur         = {p1c[31], p1c} - {p2c[31], p2c};
    dv_full      = {v1c[31], v1c} - {v2c[31], v2c};
    dv           = sat32(SATW'(dv_full));
    stretch_full = $signed({1'b0, dist_r}) - $signed({4'b0000, rest_r});
    stretch      = sat32(SATW'(stretch_full));
    prod_sh      = prod >>> FRAC_BITS;

    dneg   = d_r[axis_r][32];
    dmag   = dneg ? 33'(-d_r[axis_r]) : 33'(d_r[axis_r]);
    unit_q = $signed({1'b0, quo[FRAC_BITS:0]});
    unit_s = dneg ? -unit_q : unit_q;

    damp      = sat32(SATW'(prod_sh));
    force_nxt = sat32(-SATW'(spring_r) - SATW'(damp));

    // The second body feels the reaction force.
    fcur = force_r[axis_r];
    fext = {fcur[31], fcur};
    fsig = body_r ? -fext : fext;
    fmag = fsig[32] ? 33'(-fsig) : 33'(fsig);
    qs   = $signed(SATW'(quo));
    acc_div = sat32(fsig[32] ? -qs : qs);
    acc_eff = (axis_r == AXIS_Y) ? sat32(SATW'(acc_r) - GRAV) : acc_r;

    vel_nxt = sat32(SATW'(vcur) + SATW'(prod_sh));
    pos_nxt = sat32(SATW'(pcur) + SATW'(prod_sh));
  end

  // Requests to the shared unit.
  always_comb begin
    ucmd.start = 1'b0;
    ucmd.op    = OP_MUL;
    mul_a      = '0;
    mul_b      = '0;
    div_num    = '0;
    div_den    = '0;
    unique case (state_r)
      S_SQ_MUL: begin
        ucmd.start = 1'b1;
        mul_a      = MUL_W'(dcur);
        mul_b      = MUL_W'(dcur);
      end
      S_SQRT_ST: begin
        ucmd.start = 1'b1;
        ucmd.op    = OP_SQRT;
      end
      S_MAG_MUL: begin
        ucmd.start = 1'b1;
        mul_a      = $signed({3'b000, stiff_r});
        mul_b      = MUL_W'(stretch);
      end
      S_UNIT_ST: begin
        ucmd.start = 1'b1;
        ucmd.op    = OP_DIV;
        div_num    = {dmag, {FRAC_BITS{1'b0}}};
        div_den    = dist_r;
      end
      S_UNIT_W: begin
        ucmd.start = stat.done;
        mul_a      = MUL_W'(mag_r);
        mul_b      = MUL_W'(unit_s);
      end
      S_DAMP_MUL: begin
        ucmd.start = 1'b1;
        mul_a      = $signed({3'b000, damp_c_r});
        mul_b      = MUL_W'(dv);
      end
      S_ACC_ST: begin
        ucmd.start = (mass != '0);
        ucmd.op    = OP_DIV;
        div_num    = {fmag, {FRAC_BITS{1'b0}}};
        div_den    = DEN_W'(mass);
      end
      S_VEL_MUL: begin
        ucmd.start = 1'b1;
        mul_a      = MUL_W'(acc_eff);
        mul_b      = $signed({18'd0, dt_r});
      end
      S_POS_MUL: begin
        ucmd.start = 1'b1;
        mul_a      = MUL_W'(vcur);
        mul_b      = $signed({18'd0, dt_r});
      end
      default: ;
    endcase
  end

  sde_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ucmd),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .div_num (div_num),
    .div_den (div_den),
    .rad     ({2'b00, sum_r}),
    .prod    (prod),
    .quo     (quo),
    .stat    (stat)
  );

  // Working values of the step; no reset needed.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          dt_r  <= in_time_step;
          sum_r <= '0;
        end
      end
      S_SQ_MUL:  d_r[axis_r] <= dcur;
      S_SQ_ACC:  sum_r <= sum_r + prod[SUM_W-1:0];
      S_SQRT_W: begin
        if (stat.done) begin
          dist_r   <= quo[DEN_W-1:0];
          spring_r <= '0;
        end
      end
      S_MAG_SAT: mag_r <= sat32(SATW'(prod_sh));
      S_SPRING:  spring_r <= prod_sh[32:0];
      S_FORCE:   force_r[axis_r] <= force_nxt;
      S_ACC_ST: begin
        if (mass == '0) begin
          acc_r <= '0;
        end
      end
      S_ACC_W: begin
        if (stat.done) begin
          acc_r <= acc_div;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_pos_r[0] <= p1_r[0];
          out_pos_r[1] <= p1_r[1];
          out_pos_r[2] <= p1_r[2];
          out_pos_r[3] <= p2_r[0];
          out_pos_r[4] <= p2_r[1];
          out_pos_r[5] <= p2_r[2];
          out_sep_r    <= last_sep_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_X;
      body_r      <= 1'b0;
      out_valid_r <= 1'b0;
      stiff_r     <= CFG_ONE;
      rest_r      <= CFG_ONE;
      damp_c_r    <= '0;
      mass1_r     <= CFG_ONE;
      mass2_r     <= CFG_ONE;
      last_sep_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= '0;
        p2_r[i] <= '0;
        v1_r[i] <= '0;
        v2_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STIFF: stiff_r  <= cfg_data;
          REG_REST:  rest_r   <= cfg_data;
          REG_DAMP:  damp_c_r <= cfg_data;
          REG_MASS1: mass1_r  <= cfg_data;
          REG_MASS2: mass2_r  <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_cmd == CMD_LOAD) begin
              if (in_axis != AXIS_NONE) begin
                unique case ({in_mass_index, in_quantity})
                  {1'b0, QTY_POS}: p1_r[in_axis] <= in_load_value;
                  {1'b0, QTY_VEL}: v1_r[in_axis] <= in_load_value;
                  {1'b1, QTY_POS}: p2_r[in_axis] <= in_load_value;
                  default:         v2_r[in_axis] <= in_load_value;
                endcase
              end
              state_r <= S_FINISH;
            end else begin
              axis_r  <= AXIS_X;
              body_r  <= 1'b0;
              state_r <= S_SQ_MUL;
            end
          end
        end
        S_SQ_MUL: state_r <= S_SQ_ACC;
        S_SQ_ACC: begin
          if (axis_r == AXIS_Z) begin
            axis_r  <= AXIS_X;
            state_r <= S_SQRT_ST;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= S_SQ_MUL;
          end
        end
        S_SQRT_ST: state_r <= S_SQRT_W;
        S_SQRT_W: begin
          if (stat.done) begin
            last_sep_r <= (quo[DW-1:31] != '0) ? '1 : quo[30:0];
            // Coincident bodies get no spring term, only damping.
            state_r    <= (quo[DEN_W-1:0] != '0) ? S_MAG_MUL : S_DAMP_MUL;
          end
        end
        S_MAG_MUL:  state_r <= S_MAG_SAT;
        S_MAG_SAT:  state_r <= S_UNIT_ST;
        S_UNIT_ST:  state_r <= S_UNIT_W;
        S_UNIT_W: begin
          if (stat.done) begin
            state_r <= S_SPRING;
          end
        end
        S_SPRING:   state_r <= S_DAMP_MUL;
        S_DAMP_MUL: state_r <= S_FORCE;
        S_FORCE: begin
          if (axis_r == AXIS_Z) begin
            axis_r  <= AXIS_X;
            body_r  <= 1'b0;
            state_r <= S_ACC_ST;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= (dist_r != '0) ? S_UNIT_ST : S_DAMP_MUL;
          end
        end
        S_ACC_ST: state_r <= (mass == '0) ? S_VEL_MUL : S_ACC_W;
        S_ACC_W: begin
          if (stat.done) begin
            state_r <= S_VEL_MUL;
          end
        end
        S_VEL_MUL: state_r <= S_VEL_UPD;
        S_VEL_UPD: begin
          if (body_r) begin
            v2_r[axis_r] <= vel_nxt;
          end else begin
            v1_r[axis_r] <= vel_nxt;
          end
          state_r <= S_POS_MUL;
        end
        S_POS_MUL: state_r <= S_POS_UPD;
        S_POS_UPD: begin
          if (body_r) begin
            p2_r[axis_r] <= pos_nxt;
          end else begin
            p1_r[axis_r] <= pos_nxt;
          end
          if (axis_r == AXIS_Z) begin
            axis_r <= AXIS_X;
            if (body_r) begin
              state_r <= S_FINISH;
            end else begin
              body_r  <= 1'b1;
              state_r <= S_ACC_ST;
            end
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= S_ACC_ST;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_first_x    = out_pos_r[0];
  assign out_first_y    = out_pos_r[1];
  assign out_first_z    = out_pos_r[2];
  assign out_second_x   = out_pos_r[3];
  assign out_second_y   = out_pos_r[4];
  assign out_second_z   = out_pos_r[5];
  assign out_separation = out_sep_r;

  `SDE_ASSERT(a_step_starts_at_x, clk, rst_n, (in_acc && in_cmd == CMD_STEP) |=> (state_r == S_SQ_MUL && axis_r == AXIS_X))
  `SDE_ASSERT(a_done_in_wait, clk, rst_n, stat.done |-> (state_r == S_SQRT_W || state_r == S_UNIT_W || state_r == S_ACC_W))
  `SDE_ASSERT(a_finish_handoff, clk, rst_n, (state_r == S_FINISH && out_free) |=> (out_valid_r && state_r == S_IDLE))
  `SDE_ASSERT(a_axis_in_range, clk, rst_n, (state_r != S_IDLE) |-> axis_r != AXIS_NONE)

endmodule

`default_nettype wire
